// ===== src/wai_pkg.sv =====
// ----------------------------------------------------------------------------
// wai_pkg: shared widths and types for the wrapped angle interpolator
// Angle and blend-fraction formats, pipeline control word.
// ----------------------------------------------------------------------------
package wai_pkg;

  localparam int ANGLE_BITS      = 16;
  localparam int ALPHA_FRAC_BITS = 16;
  localparam int THRESH_BITS     = 15;
  localparam int BLEND_BITS      = 19;

  localparam int ALPHA_W = ALPHA_FRAC_BITS + 1;
  localparam int MAG_W   = ANGLE_BITS + 1;
  localparam int PROD_W  = ANGLE_BITS + ALPHA_W + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;
  localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (ALPHA_FRAC_BITS - 1);

  localparam logic REQ_STEP  = 1'b0;
  localparam logic REQ_BLEND = 1'b1;

  typedef struct packed {
    logic en1;
    logic en2;
    logic en_out;
  } stage_ctrl_t;

endpackage

// ===== src/wrapped_angle_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// wrapped_angle_interpolator_unit: three-lane binary angle interpolator
// Shortest-path step or blend of X, Y and Z angles with a match flag.
// ----------------------------------------------------------------------------
//  channel | handshake            | word
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_stall  | req_type, from_*, to_*, step_rate,
//          |                      | blend_factor, tolerance
//  output  | out_valid / out_stall| new_x, new_y, new_z, all_match
//
//  One word per cycle while in_stall is low; a result word is presented
//  through three registers (difference stage, blend multiply-add stage,
//  output register).
//  rst clears the stage valid bits only.
//  out_stall holds the output register; bubbles in the pipe still fill, and
//  in_stall rises only when every stage holds a word.
// ----------------------------------------------------------------------------
module wrapped_angle_interpolator_unit (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   req_type,
  input  logic signed [15:0]                     from_x,
  input  logic signed [15:0]                     from_y,
  input  logic signed [15:0]                     from_z,
  input  logic signed [15:0]                     to_x,
  input  logic signed [15:0]                     to_y,
  input  logic signed [15:0]                     to_z,
  input  logic [14:0]                            step_rate,
  input  logic signed [18:0]                     blend_factor,
  input  logic [14:0]                            tolerance,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [15:0]                     new_x,
  output logic signed [15:0]                     new_y,
  output logic signed [15:0]                     new_z,
  output logic                                   all_match
);

  localparam int BW = wai_pkg::BLEND_BITS;
  localparam int LW = wai_pkg::ALPHA_W;

  wai_pkg::stage_ctrl_t ctrl;

  logic v1;
  logic v2;

  logic [BW-1:0] blend_mag;
  logic [LW-1:0] alpha;

  logic [wai_pkg::ANGLE_BITS-1:0] lane_x;
  logic [wai_pkg::ANGLE_BITS-1:0] lane_y;
  logic [wai_pkg::ANGLE_BITS-1:0] lane_z;
  logic [2:0]                     lane_match;

  assign ctrl.en_out = !out_valid || !out_stall;
  assign ctrl.en2    = !v2 || ctrl.en_out;
  assign ctrl.en1    = !v1 || ctrl.en2;
  assign in_stall    = !ctrl.en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ctrl.en1) begin
        v1 <= in_valid;
      end
      if (ctrl.en2) begin
        v2 <= v1;
      end
    end
  end

  assign blend_mag = blend_factor[BW-1] ? BW'(BW'(0) - blend_factor) : blend_factor;
  assign alpha     = (blend_mag > BW'(wai_pkg::ALPHA_ONE)) ? wai_pkg::ALPHA_ONE
                                                           : LW'(blend_mag);

  wai_lane u_lane_x (
    .clk       (clk),
    .ctrl      (ctrl),
    .req_type  (req_type),
    .from_a    (from_x),
    .to_a      (to_x),
    .step_rate (step_rate),
    .alpha     (alpha),
    .tolerance (tolerance),
    .new_a     (lane_x),
    .match     (lane_match[0])
  );

  wai_lane u_lane_y (
    .clk       (clk),
    .ctrl      (ctrl),
    .req_type  (req_type),
    .from_a    (from_y),
    .to_a      (to_y),
    .step_rate (step_rate),
    .alpha     (alpha),
    .tolerance (tolerance),
    .new_a     (lane_y),
    .match     (lane_match[1])
  );

  wai_lane u_lane_z (
    .clk       (clk),
    .ctrl      (ctrl),
    .req_type  (req_type),
    .from_a    (from_z),
    .to_a      (to_z),
    .step_rate (step_rate),
    .alpha     (alpha),
    .tolerance (tolerance),
    .new_a     (lane_z),
    .match     (lane_match[2])
  );

  wai_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .lane_valid (v2),
    .lane_x     (lane_x),
    .lane_y     (lane_y),
    .lane_z     (lane_z),
    .lane_match (lane_match),
    .out_valid  (out_valid),
    .new_x      (new_x),
    .new_y      (new_y),
    .new_z      (new_z),
    .all_match  (all_match)
  );

endmodule

// ===== src/wai_lane.sv =====
// ----------------------------------------------------------------------------
// wai_lane: one angle lane of the interpolator
// Two register stages: wrapped difference and step result, then the blend
// product sum; the rounded result and select leave combinationally.
// ----------------------------------------------------------------------------
module wai_lane (
  input  logic                                  clk,
  input  wai_pkg::stage_ctrl_t                  ctrl,
  input  logic                                  req_type,
  input  logic signed [wai_pkg::ANGLE_BITS-1:0] from_a,
  input  logic signed [wai_pkg::ANGLE_BITS-1:0] to_a,
  input  logic [wai_pkg::THRESH_BITS-1:0]       step_rate,
  input  logic [wai_pkg::ALPHA_W-1:0]           alpha,
  input  logic [wai_pkg::THRESH_BITS-1:0]       tolerance,
  output logic [wai_pkg::ANGLE_BITS-1:0]        new_a,
  output logic                                  match
);

  localparam int AW = wai_pkg::ANGLE_BITS;
  localparam int MW = wai_pkg::MAG_W;
  localparam int PW = wai_pkg::PROD_W;
  localparam int FB = wai_pkg::ALPHA_FRAC_BITS;

  logic [AW-1:0] diff;
  logic [MW-1:0] diff_ext;
  logic [MW-1:0] dmag;
  logic          within_rate;
  logic          within_tol;
  logic [AW-1:0] step_val;

  logic                        s1_mode;
  logic [AW-1:0]               s1_from;
  logic [AW-1:0]               s1_to;
  logic signed [AW-1:0]        s1_diff;
  logic                        s1_snap;
  logic                        s1_match;
  logic [AW-1:0]               s1_step;
  logic [wai_pkg::ALPHA_W-1:0] s1_alpha;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] sum;

  logic                 s2_mode;
  logic [AW-1:0]        s2_to;
  logic                 s2_snap;
  logic                 s2_match;
  logic [AW-1:0]        s2_step;
  logic signed [PW-1:0] s2_sum;

  logic [PW-1:0] abs_sum;
  logic [PW-1:0] rnd_sum;
  logic [AW-1:0] rnd_q;
  logic [AW-1:0] blend_val;

  assign diff        = AW'(to_a - from_a);
  assign diff_ext    = {diff[AW-1], diff};
  assign dmag        = diff[AW-1] ? MW'(MW'(0) - diff_ext) : diff_ext;
  assign within_rate = dmag <= MW'(step_rate);
  assign within_tol  = dmag <= MW'(tolerance);
  assign step_val    = diff[AW-1] ? AW'(from_a - AW'(step_rate))
                                  : AW'(from_a + AW'(step_rate));

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      s1_mode  <= req_type;
      s1_from  <= from_a;
      s1_to    <= to_a;
      s1_diff  <= diff;
      s1_snap  <= (req_type == wai_pkg::REQ_BLEND) ? within_tol : within_rate;
      s1_match <= within_tol;
      s1_step  <= step_val;
      s1_alpha <= alpha;
    end
  end

  assign prod = PW'(s1_diff * $signed({1'b0, s1_alpha}));
  assign sum  = PW'({{(PW-AW-FB){s1_from[AW-1]}}, s1_from, FB'(0)}) + prod;

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      s2_mode  <= s1_mode;
      s2_to    <= s1_to;
      s2_snap  <= s1_snap;
      s2_match <= s1_match;
      s2_step  <= s1_step;
      s2_sum   <= sum;
    end
  end

  assign abs_sum   = s2_sum[PW-1] ? PW'(PW'(0) - s2_sum) : s2_sum;
  assign rnd_sum   = abs_sum + wai_pkg::ROUND_HALF;
  assign rnd_q     = rnd_sum[FB +: AW];
  assign blend_val = s2_sum[PW-1] ? AW'(AW'(0) - rnd_q) : rnd_q;

  assign new_a = s2_snap ? s2_to
               : ((s2_mode == wai_pkg::REQ_BLEND) ? blend_val : s2_step);
  assign match = s2_match;

endmodule

// ===== src/wai_merge.sv =====
// ----------------------------------------------------------------------------
// wai_merge: output stage of the interpolator
// Combine the lane results and match bits into the registered output word.
// ----------------------------------------------------------------------------
module wai_merge (
  input  logic                                   clk,
  input  logic                                   rst,
  input  wai_pkg::stage_ctrl_t                   ctrl,
  input  logic                                   lane_valid,
  input  logic [wai_pkg::ANGLE_BITS-1:0]         lane_x,
  input  logic [wai_pkg::ANGLE_BITS-1:0]         lane_y,
  input  logic [wai_pkg::ANGLE_BITS-1:0]         lane_z,
  input  logic [2:0]                             lane_match,
  output logic                                   out_valid,
  output logic signed [wai_pkg::ANGLE_BITS-1:0]  new_x,
  output logic signed [wai_pkg::ANGLE_BITS-1:0]  new_y,
  output logic signed [wai_pkg::ANGLE_BITS-1:0]  new_z,
  output logic                                   all_match
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.en_out) begin
      out_valid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_out) begin
      new_x     <= lane_x;
      new_y     <= lane_y;
      new_z     <= lane_z;
      all_match <= &lane_match;
    end
  end

endmodule

// ===== tb/wrapped_angle_interpolator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// wrapped_angle_interpolator_unit_tb: self-checking bench for the angle unit
// Drives directed and random step and blend words through the valid/stall
// channels with random idling on both sides. Predicts each result word from
// the accepted input word and compares it field by field, in order.
// ----------------------------------------------------------------------------
module wrapped_angle_interpolator_unit_tb;

  typedef struct {
    logic               kind;
    logic signed [15:0] src [3];
    logic signed [15:0] dst [3];
    logic [14:0]        rate;
    logic signed [18:0] blend;
    logic [14:0]        tol;
  } angle_word_t;

  typedef struct {
    logic signed [15:0] angle [3];
    logic               match;
  } angle_result_t;

  class angle_scoreboard;
    angle_result_t pending_angles [$];
    int            mismatches;

    function new();
      mismatches = 0;
    endfunction

    function angle_result_t interp_result(angle_word_t w);
      angle_result_t      r;
      logic signed [15:0] diff;
      longint             alpha, one, half, d, dmag, acc;
      one   = longint'(1) <<< wai_pkg::ALPHA_FRAC_BITS;
      half  = longint'(1) <<< (wai_pkg::ALPHA_FRAC_BITS - 1);
      alpha = (w.blend < 0) ? -longint'(w.blend) : longint'(w.blend);
      if (alpha > one) alpha = one;
      r.match = 1'b1;
      for (int i = 0; i < 3; i++) begin
        diff = w.dst[i] - w.src[i];
        d    = diff;
        dmag = (d < 0) ? -d : d;
        if (dmag > longint'(w.tol)) r.match = 1'b0;
        if (w.kind == wai_pkg::REQ_STEP) begin
          if (dmag <= longint'(w.rate)) r.angle[i] = w.dst[i];
          else if (d > 0) r.angle[i] = 16'(longint'(w.src[i]) + longint'(w.rate));
          else r.angle[i] = 16'(longint'(w.src[i]) - longint'(w.rate));
        end else if (dmag <= longint'(w.tol)) begin
          r.angle[i] = w.dst[i];
        end else begin
          acc = (longint'(w.src[i]) <<< wai_pkg::ALPHA_FRAC_BITS) + d * alpha;
          if (acc >= 0) acc = (acc + half) >>> wai_pkg::ALPHA_FRAC_BITS;
          else acc = -((half - acc) >>> wai_pkg::ALPHA_FRAC_BITS);
          r.angle[i] = 16'(acc);
        end
      end
      return r;
    endfunction

    function void note_word(angle_word_t w);
      pending_angles.push_back(interp_result(w));
    endfunction

    function int pending();
      return pending_angles.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(angle_result_t got);
      angle_result_t want;
      if (pending_angles.size() == 0) begin
        report("result word with no word pending");
        return;
      end
      want = pending_angles.pop_front();
      for (int i = 0; i < 3; i++)
        if (got.angle[i] !== want.angle[i])
          report($sformatf("lane %0d angle got %0d want %0d", i, got.angle[i],
                           want.angle[i]));
      if (got.match !== want.match)
        report($sformatf("all_match got %0b want %0b", got.match, want.match));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic signed [15:0] from_x, from_y, from_z;
  logic signed [15:0] to_x, to_y, to_z;
  logic [14:0]        step_rate;
  logic signed [18:0] blend_factor;
  logic [14:0]        tolerance;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] new_x, new_y, new_z;
  logic               all_match;

  angle_scoreboard sb = new();
  bit tx_quiet;
  bit rx_quiet;
  bit hold_req;

  wrapped_angle_interpolator_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("wrapped_angle_interpolator_unit_tb NOT OK");
    $finish;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [14:0] pick_thresh();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 15'($urandom_range(0, 400));
    if (r < 8) return 15'($urandom_range(0, 32767));
    if (r == 8) return 15'd0;
    return 15'd32767;
  endfunction

  function automatic angle_word_t mk(logic kind, int fx, int fy, int fz, int tx, int ty,
                                     int tz, int rate, int blend, int tol);
    angle_word_t w;
    w.kind   = kind;
    w.src[0] = 16'(fx);
    w.src[1] = 16'(fy);
    w.src[2] = 16'(fz);
    w.dst[0] = 16'(tx);
    w.dst[1] = 16'(ty);
    w.dst[2] = 16'(tz);
    w.rate   = 15'(rate);
    w.blend  = 19'(blend);
    w.tol    = 15'(tol);
    return w;
  endfunction

  function automatic angle_word_t rand_word();
    angle_word_t w;
    int          sel;
    int          b;
    w.kind = $urandom_range(0, 1) ? wai_pkg::REQ_BLEND : wai_pkg::REQ_STEP;
    w.rate = pick_thresh();
    w.tol  = pick_thresh();
    sel = $urandom_range(0, 9);
    if (sel < 2) b = $urandom_range(0, 262144) - 131072;
    else if (sel < 4) b = 65536 + $urandom_range(0, 64) - 32;
    else if (sel == 4) begin
      case ($urandom_range(0, 4))
        0: b = -131072;
        1: b = 131072;
        2: b = 0;
        3: b = 65536;
        default: b = -65536;
      endcase
    end else b = $urandom_range(0, 65536);
    if (sel != 4 && $urandom_range(0, 1)) b = -b;
    w.blend = 19'(b);
    for (int i = 0; i < 3; i++) begin
      w.src[i] = 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 9);
      if (sel < 4) w.dst[i] = w.src[i] + 16'($urandom_range(0, 600)) - 16'sd300;
      else if (sel == 4) begin
        case ($urandom_range(0, 2))
          0: w.dst[i] = w.src[i] + 16'h8000;
          1: w.dst[i] = w.src[i] + 16'h7fff;
          default: w.dst[i] = w.src[i] + 16'h8001;
        endcase
      end else w.dst[i] = 16'($urandom_range(0, 65535));
    end
    return w;
  endfunction

  task drive_word(angle_word_t w);
    in_valid     = 1'b1;
    req_type     = w.kind;
    from_x       = w.src[0];
    from_y       = w.src[1];
    from_z       = w.src[2];
    to_x         = w.dst[0];
    to_y         = w.dst[1];
    to_z         = w.dst[2];
    step_rate    = w.rate;
    blend_factor = w.blend;
    tolerance    = w.tol;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    @(negedge clk);
  endtask

  task idle_gap(int n);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  initial begin
    angle_result_t got;
    int            stall_left;
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got.angle[0] = new_x;
        got.angle[1] = new_y;
        got.angle[2] = new_z;
        got.match    = all_match;
        sb.check_result(got);
      end
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (200) @(negedge clk);
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (out_stall) begin
        out_stall = 1'b0;
      end else begin
        stall_left = pick_gap(rx_quiet);
        if (stall_left > 0) begin
          out_stall = 1'b1;
          stall_left--;
        end
      end
    end
  end

  initial begin
    angle_word_t directed [$];
    rst          = 1'b1;
    in_valid     = 1'b0;
    req_type     = wai_pkg::REQ_STEP;
    from_x       = '0;
    from_y       = '0;
    from_z       = '0;
    to_x         = '0;
    to_y         = '0;
    to_z         = '0;
    step_rate    = '0;
    blend_factor = '0;
    tolerance    = '0;
    tx_quiet     = 1'b0;
    rx_quiet     = 1'b0;
    hold_req     = 1'b0;

    directed.push_back(mk(wai_pkg::REQ_STEP, 0, 100, -5, 100, 0, -5, 100, 0, 0));
    directed.push_back(mk(wai_pkg::REQ_STEP, 0, 0, 0, 100, -100, 0, 99, 0, 100));
    directed.push_back(mk(wai_pkg::REQ_STEP, 10, -32768, 32767, 10, 32767, -32768,
                          0, 0, 0));
    directed.push_back(mk(wai_pkg::REQ_STEP, 0, 32767, -32768, -32768, -1, 0,
                          32767, 0, 32767));
    directed.push_back(mk(wai_pkg::REQ_STEP, 32767, -32768, 100, -32760, 32700, -100,
                          3, 0, 0));
    directed.push_back(mk(wai_pkg::REQ_STEP, -32768, -32768, -32768, 32767, 32767,
                          32767, 32767, -131072, 32767));
    directed.push_back(mk(wai_pkg::REQ_STEP, -32768, 32767, 0, 32767, -32768, -32768,
                          32767, 131072, 32767));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 1000, -1000, 3000, -3000, 5000,
                          0, 0, 0));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 1000, -1000, 3000, -3000, 5000,
                          0, 65536, 0));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 1000, -1000, 3000, -3000, 5000,
                          0, 131072, 0));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 1000, -1000, 3000, -3000, 5000,
                          0, -131072, 0));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 1000, -1000, 3000, -3000, 5000,
                          0, -100000, 0));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 0, 100, 3, -3, 103, 0, 32768, 0));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 0, 0, 3, -3, 1, 0, -32768, 2));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 0, 32767, -32768, -32768, -1, 0,
                          0, 65535, 32767));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 5, 6, 7, 5, 6, 7, 0, 12345, 0));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 30000, -30000, 20000, -30000, 30000,
                          -20000, 32767, 98304, 100));
    directed.push_back(mk(wai_pkg::REQ_BLEND, 32767, -32768, 0, -32768, 32767, 32767,
                          0, 1, 0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) begin
      drive_word(directed[i]);
      idle_gap(pick_gap(tx_quiet));
    end

    for (int blk = 0; blk < 13; blk++) begin
      tx_quiet = (blk % 4 == 1) || (blk == 5);
      rx_quiet = (blk % 3 == 2);
      if (blk == 5) hold_req = 1'b1;
      for (int k = 0; k < 100; k++) begin
        drive_word(rand_word());
        idle_gap(pick_gap(tx_quiet));
      end
      if (blk == 5 || blk == 9) drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0)
      $display("wrapped_angle_interpolator_unit_tb OK");
    else
      $display("wrapped_angle_interpolator_unit_tb NOT OK");
    $finish;
  end

endmodule
